// ===== rtl/yprgb_pkg.sv =====
// yprgb_pkg: shared types and constants for the yuv pair to rgb converter
// full-range bt.601 coefficients in fixed point with 16 fraction bits, chroma offset struct
// no dependencies

package yprgb_pkg;

  // conversion coefficients, scaled by 2^16
  localparam logic signed [17:0] COEF_RV = 18'sd91881;
  localparam logic signed [17:0] COEF_GU = 18'sd22554;
  localparam logic signed [17:0] COEF_GV = 18'sd46802;
  localparam logic signed [17:0] COEF_BU = 18'sd116130;

  // chroma bias and channel limit
  localparam logic [7:0] CHROMA_BIAS = 8'd128;
  localparam logic [7:0] CHAN_MAX    = 8'd255;

  // chroma order codes
  localparam logic CHROMA_ORDER_UV = 1'b0;
  localparam logic CHROMA_ORDER_VU = 1'b1;

  // per-channel offsets after the shift by 16, shared by both pixels
  typedef struct packed {
    logic signed [9:0] red;
    logic signed [9:0] green;
    logic signed [9:0] blue;
  } chroma_off_t;

  // one rgb pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pix_t;

endpackage

// ===== rtl/yprgb_chroma_mult.sv =====
// yprgb_chroma_mult: chroma order select, bias removal and coefficient products
// registers the three shifted chroma offsets; depends on yprgb_pkg

module yprgb_chroma_mult import yprgb_pkg::*; (
  input  logic        clk,
  input  logic        chroma_order,
  input  logic [7:0]  chroma_first,
  input  logic [7:0]  chroma_second,
  output chroma_off_t offs_r
);

  logic [7:0]         u_byte;
  logic [7:0]         v_byte;
  logic signed [8:0]  d_val;
  logic signed [8:0]  e_val;
  logic signed [26:0] prod_r;
  logic signed [26:0] prod_g;
  logic signed [26:0] prod_b;
  chroma_off_t        offs_nxt;

  // pick u and v, remove the bias
  always_comb begin
    if (chroma_order == CHROMA_ORDER_VU) begin
      u_byte = chroma_second;
      v_byte = chroma_first;
    end else begin
      u_byte = chroma_first;
      v_byte = chroma_second;
    end
    d_val = $signed({1'b0, u_byte}) - $signed({1'b0, CHROMA_BIAS});
    e_val = $signed({1'b0, v_byte}) - $signed({1'b0, CHROMA_BIAS});
  end

  // products, then arithmetic shift by 16 (floor)
  always_comb begin
    prod_r = COEF_RV * e_val;
    prod_g = (COEF_GU * d_val) + (COEF_GV * e_val);
    prod_b = COEF_BU * d_val;
    offs_nxt.red   = prod_r[25:16];
    offs_nxt.green = prod_g[25:16];
    offs_nxt.blue  = prod_b[25:16];
  end

  // offset register
  always_ff @(posedge clk) begin
    offs_r <= offs_nxt;
  end

endmodule

// ===== rtl/yprgb_pixel_clamp.sv =====
// yprgb_pixel_clamp: adds chroma offsets to one luma value and clamps to 0..255
// registers one rgb pixel; depends on yprgb_pkg

module yprgb_pixel_clamp import yprgb_pkg::*; (
  input  logic        clk,
  input  logic [7:0]  luma,
  input  chroma_off_t offs,
  output rgb_pix_t    pix_r
);

  logic signed [10:0] red_sum;
  logic signed [10:0] green_sum;
  logic signed [10:0] blue_sum;
  rgb_pix_t           pix_nxt;

  function automatic logic [7:0] clamp_chan(input logic signed [10:0] val);
    logic [7:0] res;
    if (val < 0) begin
      res = 8'd0;
    end else if (val > $signed({3'b000, CHAN_MAX})) begin
      res = CHAN_MAX;
    end else begin
      res = val[7:0];
    end
    return res;
  endfunction

  // luma plus offsets, green subtracts
  always_comb begin
    red_sum   = $signed({3'b000, luma}) + 11'(offs.red);
    green_sum = $signed({3'b000, luma}) - 11'(offs.green);
    blue_sum  = $signed({3'b000, luma}) + 11'(offs.blue);
    pix_nxt.red   = clamp_chan(red_sum);
    pix_nxt.green = clamp_chan(green_sum);
    pix_nxt.blue  = clamp_chan(blue_sum);
  end

  // pixel result register
  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

endmodule

// ===== rtl/yuv_pair_to_rgb_converter.sv =====
// yuv_pair_to_rgb_converter: top level, pixel pair ycbcr to rgb (bt.601 full range)
// uses yprgb_pkg, yprgb_chroma_mult and yprgb_pixel_clamp
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------------
//  input    | in_luma_first/second, in_chroma_*       | start high, busy low
//  result   | out_red/green/blue_first/second         | out_strobe, one cycle
//  config   | cfg_wdata (chroma_order)                | cfg_we
//
// one transaction per cycle; after acceptance the result passes in turn through the
// input register, the product register and the clamp register
// rst_n is synchronous; busy is high only while reset is applied
// the receiver cannot stall, so only reset holds off the input side

module yuv_pair_to_rgb_converter import yprgb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_luma_first,
  input  logic [7:0] in_luma_second,
  input  logic [7:0] in_chroma_first,
  input  logic [7:0] in_chroma_second,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  output logic       out_strobe,
  output logic [7:0] out_red_first,
  output logic [7:0] out_green_first,
  output logic [7:0] out_blue_first,
  output logic [7:0] out_red_second,
  output logic [7:0] out_green_second,
  output logic [7:0] out_blue_second
);

  logic        chroma_order_r;
  logic [2:0]  valid_r;
  logic [2:0]  valid_nxt;
  logic        accept;
  logic [7:0]  luma_first_r;
  logic [7:0]  luma_second_r;
  logic [7:0]  chroma_first_r;
  logic [7:0]  chroma_second_r;
  logic [7:0]  luma_first_d_r;
  logic [7:0]  luma_second_d_r;
  chroma_off_t offs;
  rgb_pix_t    pix_first;
  rgb_pix_t    pix_second;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_order_r <= CHROMA_ORDER_UV;
    end else if (cfg_we) begin
      chroma_order_r <= cfg_wdata;
    end
  end

  // valid pipeline
  assign valid_nxt = {valid_r[1:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 3'b000;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // input register, then luma delay to line up with the products
  always_ff @(posedge clk) begin
    if (accept) begin
      luma_first_r    <= in_luma_first;
      luma_second_r   <= in_luma_second;
      chroma_first_r  <= in_chroma_first;
      chroma_second_r <= in_chroma_second;
    end
    luma_first_d_r  <= luma_first_r;
    luma_second_d_r <= luma_second_r;
  end

  // shared chroma products
  yprgb_chroma_mult u_chroma_mult (
    .clk           (clk),
    .chroma_order  (chroma_order_r),
    .chroma_first  (chroma_first_r),
    .chroma_second (chroma_second_r),
    .offs_r        (offs)
  );

  // left and right pixel
  yprgb_pixel_clamp u_clamp_first (
    .clk   (clk),
    .luma  (luma_first_d_r),
    .offs  (offs),
    .pix_r (pix_first)
  );

  yprgb_pixel_clamp u_clamp_second (
    .clk   (clk),
    .luma  (luma_second_d_r),
    .offs  (offs),
    .pix_r (pix_second)
  );

  // result ports
  assign out_strobe       = valid_r[2];
  assign out_red_first    = pix_first.red;
  assign out_green_first  = pix_first.green;
  assign out_blue_first   = pix_first.blue;
  assign out_red_second   = pix_second.red;
  assign out_green_second = pix_second.green;
  assign out_blue_second  = pix_second.blue;

endmodule

// ===== rtl/yprgb_checker.sv =====
// yprgb_checker: port-level assertions for yuv_pair_to_rgb_converter
// bound to the top level below; depends on nothing else

module yprgb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [7:0] in_luma_first,
  input logic [7:0] in_luma_second,
  input logic [7:0] in_chroma_first,
  input logic [7:0] in_chroma_second,
  input logic       out_strobe,
  input logic [7:0] out_red_first,
  input logic [7:0] out_green_first,
  input logic [7:0] out_blue_first,
  input logic [7:0] out_red_second,
  input logic [7:0] out_green_second,
  input logic [7:0] out_blue_second
);

  // every accepted transaction is followed by a result strobe
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("accepted transaction produced no result");

  // no result without a matching earlier transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 3))
    else $error("result without a matching transaction");

  // reset flushes the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // neutral chroma passes luma straight through as gray
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_chroma_first == 8'd128 && in_chroma_second == 8'd128)
    |-> ##3 (out_red_first == $past(in_luma_first, 3)
          && out_green_first == $past(in_luma_first, 3)
          && out_blue_first == $past(in_luma_first, 3)
          && out_red_second == $past(in_luma_second, 3)
          && out_green_second == $past(in_luma_second, 3)
          && out_blue_second == $past(in_luma_second, 3)))
    else $error("neutral chroma did not give gray output");

endmodule

bind yuv_pair_to_rgb_converter yprgb_checker u_yprgb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_luma_first    (in_luma_first),
  .in_luma_second   (in_luma_second),
  .in_chroma_first  (in_chroma_first),
  .in_chroma_second (in_chroma_second),
  .out_strobe       (out_strobe),
  .out_red_first    (out_red_first),
  .out_green_first  (out_green_first),
  .out_blue_first   (out_blue_first),
  .out_red_second   (out_red_second),
  .out_green_second (out_green_second),
  .out_blue_second  (out_blue_second)
);
